// ===== hw/rtl/e2c_pkg.sv =====
// Package with the types, constants and calendar tables of the epoch-to-calendar converter.
`default_nettype none

package e2c_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TZ,
        ST_DAY,
        ST_HOUR,
        ST_MIN,
        ST_WDAY,
        ST_YEAR,
        ST_MONTH,
        ST_OUT
    } t_state;

    localparam logic CFG_TZ_OFFSET   = 1'b0;
    localparam logic CFG_TWELVE_HOUR = 1'b1;

    localparam int unsigned SEC_PER_DAY  = 86400;
    localparam int unsigned SEC_PER_HOUR = 3600;
    localparam int unsigned SEC_PER_MIN  = 60;
    localparam int unsigned DAYS_PER_WK  = 7;

    localparam int unsigned DAY_STEPS  = 16;
    localparam int unsigned HOUR_STEPS = 5;
    localparam int unsigned MIN_STEPS  = 6;
    localparam int unsigned WDAY_STEPS = 13;

    localparam logic [31:0] DAY_DVS_INIT  = 32'(SEC_PER_DAY) << (DAY_STEPS - 1);
    localparam logic [31:0] HOUR_DVS_INIT = 32'(SEC_PER_HOUR) << (HOUR_STEPS - 1);
    localparam logic [31:0] MIN_DVS_INIT  = 32'(SEC_PER_MIN) << (MIN_STEPS - 1);
    localparam logic [31:0] WDAY_DVS_INIT = 32'(DAYS_PER_WK) << (WDAY_STEPS - 1);

    localparam logic [7:0] YEAR_2000 = 8'd30;
    localparam logic [7:0] YEAR_2100 = 8'd130;
    localparam logic [3:0] MONTH_FEB = 4'd1;
    localparam logic [2:0] EPOCH_WDAY = 3'd4;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [31:0] diff;
        logic        ge;
    } t_alu_rsp;

    // Negated offset in seconds, modulo 2^32, so that the unit subtracts it.
    function automatic logic [31:0] tz_neg_offset(input logic signed [4:0] tz);
        logic signed [31:0] w;
        w = 32'(tz);
        return 32'(-(w * 32'sd3600));
    endfunction

    // Years counted from 1970. 2100 is the only century year in range that is not a leap year.
    function automatic logic is_leap(input logic [7:0] year);
        return (year[1:0] == 2'd2) && (year != YEAR_2100);
    endfunction

    function automatic logic [8:0] year_len(input logic [7:0] year);
        return is_leap(year) ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/e2c_alu.sv =====
// Shared subtract and compare unit used for every step of the conversion.
`default_nettype none

module e2c_alu (
    input  var e2c_pkg::t_alu_req i_req,
    output var e2c_pkg::t_alu_rsp o_rsp
);
    import e2c_pkg::*;

    logic [32:0] w_sub;

    assign w_sub      = {1'b0, i_req.a} - {1'b0, i_req.b};
    assign o_rsp.diff = w_sub[31:0];
    assign o_rsp.ge   = ~w_sub[32];

endmodule

`default_nettype wire

// ===== hw/rtl/epoch_to_calendar.sv =====
// Top level of the converter from Unix timestamps to calendar fields.
//
// One beat on the slave stream carries a 32-bit timestamp. One beat on the master stream
// returns the calendar fields for it. The configuration channel writes the timezone offset
// (index 0) and the 12-hour mode bit (index 1); it is always ready. The user is to write
// it only while idle; the block itself does not enforce this. A single subtractor does
// the offset step, the restoring divisions by 86400, 3600, 60 and 7, then the walk year
// by year since 1970 and then month by month, all under a sequencer.
// The slave side is ready only while the block is idle.
// The result waits in its registers while the receiver stalls; the block takes no new
// timestamp until the result beat completes.
// Reset clears the sequencer and both configuration registers to zero.
`default_nettype none

module epoch_to_calendar (
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    input  var logic        s_axis_tvalid,
    output var logic        s_axis_tready,
    // Fields from bit 0: epoch_seconds[31:0].
    input  var logic [31:0] s_axis_tdata,
    output var logic        m_axis_tvalid,
    input  var logic        m_axis_tready,
    // Fields from bit 0: second_of_minute[5:0], minute_of_hour[11:6], hour_value[16:12],
    // pm_flag[17], weekday[20:18], day_of_month[25:21], month_number[29:26],
    // year_since_2000[37:30], year_valid[38], zero fill[39].
    output var logic [39:0] m_axis_tdata,
    input  var logic        i_cfg_valid,
    output var logic        o_cfg_ready,
    input  var logic        i_cfg_index,
    input  var logic [4:0]  i_cfg_data
);
    import e2c_pkg::*;

    t_state r_state, n_state;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_dvs, n_dvs;
    logic [15:0] r_quo, n_quo;
    logic [3:0]  r_cnt, n_cnt;
    logic [15:0] r_days, n_days;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_min, n_min;
    logic [5:0]  r_sec, n_sec;
    logic [2:0]  r_wday, n_wday;
    logic [7:0]  r_year, n_year;
    logic [3:0]  r_month, n_month;
    logic signed [4:0] r_tz;
    logic        r_twelve;

    t_alu_req    w_req;
    t_alu_rsp    w_rsp;
    logic [15:0] w_quo;
    logic [3:0]  w_wsum;
    logic [3:0]  w_wmod;
    logic [4:0]  w_hour;
    logic        w_pm;

    e2c_alu u_alu (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tz     <= '0;
            r_twelve <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TZ_OFFSET:   r_tz     <= i_cfg_data;
                CFG_TWELVE_HOUR: r_twelve <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_dvs   <= n_dvs;
        r_quo   <= n_quo;
        r_cnt   <= n_cnt;
        r_days  <= n_days;
        r_hour  <= n_hour;
        r_min   <= n_min;
        r_sec   <= n_sec;
        r_wday  <= n_wday;
        r_year  <= n_year;
        r_month <= n_month;
    end

    assign w_quo  = {r_quo[14:0], w_rsp.ge};
    assign w_wsum = {1'b0, w_rsp.ge ? w_rsp.diff[2:0] : r_rem[2:0]} + {1'b0, EPOCH_WDAY};
    assign w_wmod = (w_wsum >= 4'(DAYS_PER_WK)) ? w_wsum - 4'(DAYS_PER_WK) : w_wsum;

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_days  = r_days;
        n_hour  = r_hour;
        n_min   = r_min;
        n_sec   = r_sec;
        n_wday  = r_wday;
        n_year  = r_year;
        n_month = r_month;
        w_req.a = r_rem;
        w_req.b = r_dvs;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;

        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_rem   = s_axis_tdata;
                    n_state = ST_TZ;
                end
            end
            ST_TZ: begin
                w_req.b = tz_neg_offset(r_tz);
                n_rem   = w_rsp.diff;
                n_dvs   = DAY_DVS_INIT;
                n_cnt   = 4'(DAY_STEPS - 1);
                n_quo   = '0;
                n_state = ST_DAY;
            end
            ST_DAY, ST_HOUR, ST_MIN, ST_WDAY: begin
                if (w_rsp.ge) begin
                    n_rem = w_rsp.diff;
                end
                n_quo = w_quo;
                n_dvs = r_dvs >> 1;
                n_cnt = r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    n_quo = '0;
                    case (r_state)
                        ST_DAY: begin
                            n_days  = w_quo;
                            n_dvs   = HOUR_DVS_INIT;
                            n_cnt   = 4'(HOUR_STEPS - 1);
                            n_state = ST_HOUR;
                        end
                        ST_HOUR: begin
                            n_hour  = w_quo[4:0];
                            n_dvs   = MIN_DVS_INIT;
                            n_cnt   = 4'(MIN_STEPS - 1);
                            n_state = ST_MIN;
                        end
                        ST_MIN: begin
                            n_min   = w_quo[5:0];
                            n_sec   = w_rsp.ge ? w_rsp.diff[5:0] : r_rem[5:0];
                            n_rem   = {16'd0, r_days};
                            n_dvs   = WDAY_DVS_INIT;
                            n_cnt   = 4'(WDAY_STEPS - 1);
                            n_state = ST_WDAY;
                        end
                        default: begin
                            n_wday  = 3'(w_wmod + 4'd1);
                            n_rem   = {16'd0, r_days};
                            n_year  = '0;
                            n_state = ST_YEAR;
                        end
                    endcase
                end
            end
            ST_YEAR: begin
                w_req.b = 32'(year_len(r_year));
                if (w_rsp.ge) begin
                    n_rem  = w_rsp.diff;
                    n_year = r_year + 8'd1;
                end else begin
                    n_month = '0;
                    n_state = ST_MONTH;
                end
            end
            ST_MONTH: begin
                w_req.b = 32'(month_len(r_month, is_leap(r_year)));
                if (w_rsp.ge) begin
                    n_rem   = w_rsp.diff;
                    n_month = r_month + 4'd1;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_hour = r_hour;
        w_pm   = 1'b0;
        if (r_twelve) begin
            if (r_hour == 5'd0) begin
                w_hour = 5'd12;
            end else if (r_hour == 5'd12) begin
                w_pm = 1'b1;
            end else if (r_hour > 5'd12) begin
                w_hour = r_hour - 5'd12;
                w_pm   = 1'b1;
            end
        end
    end

    assign m_axis_tdata = {
        1'b0,
        (r_year >= YEAR_2000),
        8'(r_year - YEAR_2000),
        4'(r_month + 4'd1),
        5'(r_rem[4:0] + 5'd1),
        r_wday,
        w_pm,
        w_hour,
        r_min,
        r_sec
    };

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == ST_TZ))
        else $error("accepted beat did not start the conversion");

    a_out_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
        else $error("block not idle after result beat");

    a_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_YEAR) |-> (r_year < 8'd137))
        else $error("year walk ran past the timestamp range");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((r_month < 4'd12) && (r_rem < 32'd31)))
        else $error("month or day out of range");

endmodule

`default_nettype wire
